>>> sv/sgm_pkg.sv
// Package for the gated SiLU multiply block: field widths, default parameters,
// saturation limits and the elaboration-time builder of the sigmoid knot table.
// No dependencies.
package sgm_pkg;

  localparam int unsigned DEF_FRAC_BITS        = 12;
  localparam int unsigned DEF_SIGMOID_SEGMENTS = 64;

  localparam int unsigned OPERAND_W = 16;

  localparam logic signed [OPERAND_W-1:0] PRODUCT_MAX = 16'sh7FFF;
  localparam logic signed [OPERAND_W-1:0] PRODUCT_MIN = 16'sh8000;

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  // Shift-subtract divide, used only while building constants.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [63:0] rem;
    int          i;
    quo = '0;
    rem = '0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Knot k of the sigmoid table, at p = -8 + 16k/segs. e^(-1/segs) comes from a
  // truncated Taylor sum in Q30, raised to |16k - 8 segs| by repeated multiply.
  function automatic logic [31:0] knot_value(input int unsigned k, input int unsigned segs,
                                             input int unsigned frac);
    logic [63:0] b;
    logic [63:0] term;
    logic [63:0] v;
    logic [63:0] den;
    logic [63:0] q;
    int          n;
    int          a;
    int          j;
    int          i;
    b    = Q30_ONE;
    term = Q30_ONE;
    for (j = 1; j <= 12; j++) begin
      term = udiv64(term, 64'(segs) * 64'(j));
      if (j % 2 == 1) begin
        b = b - term;
      end else begin
        b = b + term;
      end
    end
    n = 16 * int'(k) - 8 * int'(segs);
    a = (n < 0) ? -n : n;
    v = Q30_ONE;
    for (i = 0; i < a; i++) begin
      v = (v * b) >> 30;
    end
    den = Q30_ONE + v;
    q   = udiv64((v << frac) + (den >> 1), den);
    if (n < 0) begin
      return q[31:0];
    end
    return 32'((64'd1 << frac) - q);
  endfunction

endpackage

>>> sv/sgm_in_if.sv
// Input channel of the gated SiLU multiply block: valid/ready plus one operand pair.
// Depends on sgm_pkg.
interface sgm_in_if;
  import sgm_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [OPERAND_W-1:0]   silu_operand;
  logic signed [OPERAND_W-1:0]   scale_operand;
  logic                          row_end;
  logic                          batch_end;

  modport source (
    output valid, silu_operand, scale_operand, row_end, batch_end,
    input  ready
  );

  modport sink (
    input  valid, silu_operand, scale_operand, row_end, batch_end,
    output ready
  );

endinterface

>>> sv/sgm_out_if.sv
// Output channel of the gated SiLU multiply block: valid/ready plus one result.
// Depends on sgm_pkg.
interface sgm_out_if;
  import sgm_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [OPERAND_W-1:0]   product;
  logic                          saturated;
  logic                          row_end_out;
  logic                          batch_end_out;

  modport source (
    output valid, product, saturated, row_end_out, batch_end_out,
    input  ready
  );

  modport sink (
    input  valid, product, saturated, row_end_out, batch_end_out,
    output ready
  );

endinterface

>>> sv/sgm_knot_lut.sv
// Sigmoid knot table and segment fetch: base knot and rise to the next knot.
// Depends on sgm_pkg (knot_value builds the table at elaboration).
module sgm_knot_lut #(
  parameter int unsigned FRAC_BITS        = sgm_pkg::DEF_FRAC_BITS,
  parameter int unsigned SIGMOID_SEGMENTS = sgm_pkg::DEF_SIGMOID_SEGMENTS
) (
  input  logic [$clog2(SIGMOID_SEGMENTS+1)-1:0] seg_i,
  output logic [FRAC_BITS:0]                    lo_o,
  output logic [FRAC_BITS:0]                    diff_o
);
  import sgm_pkg::*;

  localparam int unsigned KW = FRAC_BITS + 1;
  localparam int unsigned SW = $clog2(SIGMOID_SEGMENTS + 1);

  logic [KW-1:0] knot [SIGMOID_SEGMENTS+1];
  logic [SW-1:0] seg_nx;

  for (genvar g = 0; g <= SIGMOID_SEGMENTS; g++) begin : g_knot
    localparam logic [31:0] KV = knot_value(g, SIGMOID_SEGMENTS, FRAC_BITS);
    assign knot[g] = KV[KW-1:0];
  end

  assign seg_nx = seg_i + SW'(1);

  always_comb begin
    if (seg_i >= SW'(SIGMOID_SEGMENTS)) begin
      // top end of the clamped range: flat at the last knot
      lo_o   = knot[SIGMOID_SEGMENTS];
      diff_o = '0;
    end else begin
      lo_o   = knot[seg_i];
      diff_o = knot[seg_nx] - knot[seg_i];
    end
  end

endmodule

>>> sv/silu_gated_multiply_top.sv
// Gated SiLU multiply: product = x * sigmoid(x) * y in signed fixed point.
// Depends on sgm_pkg, sgm_in_if, sgm_out_if and sgm_knot_lut.
//
// Usage:
//   in_i  takes one (silu_operand, scale_operand) pair per transfer, with the
//         row_end and batch_end marks; out_o gives one result per pair, in
//         order, with saturated set when the product was clipped to 16 bits
//         and the marks copied through.
//   The transfer edge loads the first of seven register stages; throughput is
//   one pair per cycle while out_o.ready is high. The pipeline runs clamp and
//   segment scale, knot fetch, slope multiply, interpolation add, x * sigmoid,
//   times y, and round and saturate, one register stage each.
//   Each stage has its own valid bit and moves whenever the stage after it is
//   empty or moving, so bubbles close up behind a stalled output and in_i.ready
//   stays high until all seven stages hold a result. When out_o.ready is low
//   the output register holds its result.
//   Reset clears all valid bits; the knot table is a constant and needs no
//   set-up, so pairs are taken in the first cycle after reset.
module silu_gated_multiply_top #(
  parameter int unsigned FRAC_BITS        = sgm_pkg::DEF_FRAC_BITS,
  parameter int unsigned SIGMOID_SEGMENTS = sgm_pkg::DEF_SIGMOID_SEGMENTS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  sgm_in_if.sink   in_i,
  sgm_out_if.source out_o
);
  import sgm_pkg::*;

  localparam int unsigned NS  = 7;
  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned KW  = F + 1;
  localparam int unsigned SW  = $clog2(SIGMOID_SEGMENTS + 1);
  localparam int unsigned CW  = (F + 5 > OPERAND_W + 1) ? F + 5 : OPERAND_W + 1;
  localparam int unsigned DW  = F + 5;
  localparam int unsigned RFW = F + 4;
  localparam int unsigned TW  = RFW + SW;
  localparam int unsigned PW  = KW + RFW;
  localparam int unsigned XSW = OPERAND_W + F;
  localparam int unsigned FW  = XSW + OPERAND_W;
  localparam int unsigned RW  = FW - 2 * F;

  localparam logic signed [CW-1:0] LIM_P    = signed'(CW'(1) << (F + 3));
  localparam logic signed [CW-1:0] LIM_N    = -LIM_P;
  localparam logic [TW-1:0]        SEGS_T   = TW'(SIGMOID_SEGMENTS);
  localparam logic signed [FW-1:0] HALF     = signed'(FW'(1) << (2 * F - 1));
  localparam logic signed [RW-1:0] RES_MAX  = RW'(PRODUCT_MAX);
  localparam logic signed [RW-1:0] RES_MIN  = RW'(PRODUCT_MIN);
  localparam logic [KW-1:0]        SIG_ONE  = KW'(1) << F;

  // handshake
  logic [NS-1:0] v_q, v_d;
  logic [NS-1:0] stage_rdy;
  logic [NS-1:0] ld;

  // marks travel with every stage
  logic [NS-1:0] row_q;
  logic [NS-1:0] batch_q;

  // stage 0: clamp and segment scale
  logic signed [CW-1:0]        x_ext;
  logic signed [CW-1:0]        x_clamp;
  logic [DW-1:0]               d_pos;
  logic [TW-1:0]               t_scaled;
  logic [SW-1:0]               s0_seg_q;
  logic [RFW-1:0]              s0_r_q;
  logic signed [OPERAND_W-1:0] s0_x_q, s0_y_q;

  // stage 1: knot fetch
  logic [KW-1:0]               lut_lo, lut_diff;
  logic [KW-1:0]               s1_lo_q, s1_diff_q;
  logic [RFW-1:0]              s1_r_q;
  logic signed [OPERAND_W-1:0] s1_x_q, s1_y_q;

  // stage 2: slope times remainder
  logic [PW-1:0]               slope_prod;
  logic [KW-1:0]               s2_frac_q, s2_lo_q;
  logic signed [OPERAND_W-1:0] s2_x_q, s2_y_q;

  // stage 3: interpolated sigmoid
  logic [KW-1:0]               s3_sig_q;
  logic signed [OPERAND_W-1:0] s3_x_q, s3_y_q;

  // stage 4: x * sigmoid
  logic signed [XSW-1:0]       s4_xs_q;
  logic signed [OPERAND_W-1:0] s4_y_q;

  // stage 5: times y
  logic signed [FW-1:0]        s5_full_q;

  // stage 6: round and saturate
  logic signed [FW-1:0]        rnd_sum;
  logic signed [RW-1:0]        rnd_res;
  logic signed [OPERAND_W-1:0] sat_res;
  logic                        sat_flag;
  logic signed [OPERAND_W-1:0] s6_product_q;
  logic                        s6_sat_q;

  // ---------------------------------------------------------------- control
  always_comb begin
    stage_rdy[NS-1] = !v_q[NS-1] || out_o.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      stage_rdy[k] = !v_q[k] || stage_rdy[k+1];
    end
  end

  always_comb begin
    ld[0]  = stage_rdy[0] && in_i.valid;
    v_d[0] = stage_rdy[0] ? in_i.valid : v_q[0];
    for (int k = 1; k < NS; k++) begin
      ld[k]  = stage_rdy[k] && v_q[k-1];
      v_d[k] = stage_rdy[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      row_q[0]   <= in_i.row_end;
      batch_q[0] <= in_i.batch_end;
    end
    for (int k = 1; k < NS; k++) begin
      if (ld[k]) begin
        row_q[k]   <= row_q[k-1];
        batch_q[k] <= batch_q[k-1];
      end
    end
  end

  assign in_i.ready = stage_rdy[0];

  // ---------------------------------------------------------------- stage 0
  always_comb begin
    x_ext = CW'(in_i.silu_operand);
    if (x_ext < LIM_N) begin
      x_clamp = LIM_N;
    end else if (x_ext > LIM_P) begin
      x_clamp = LIM_P;
    end else begin
      x_clamp = x_ext;
    end
    d_pos    = DW'(unsigned'(x_clamp + LIM_P));
    t_scaled = TW'(d_pos) * SEGS_T;
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      s0_seg_q <= t_scaled[TW-1:RFW];
      s0_r_q   <= t_scaled[RFW-1:0];
      s0_x_q   <= in_i.silu_operand;
      s0_y_q   <= in_i.scale_operand;
    end
  end

  // ---------------------------------------------------------------- stage 1
  sgm_knot_lut #(
    .FRAC_BITS       (FRAC_BITS),
    .SIGMOID_SEGMENTS(SIGMOID_SEGMENTS)
  ) u_knot_lut (
    .seg_i (s0_seg_q),
    .lo_o  (lut_lo),
    .diff_o(lut_diff)
  );

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      s1_lo_q   <= lut_lo;
      s1_diff_q <= lut_diff;
      s1_r_q    <= s0_r_q;
      s1_x_q    <= s0_x_q;
      s1_y_q    <= s0_y_q;
    end
  end

  // ---------------------------------------------------------------- stage 2
  assign slope_prod = PW'(s1_diff_q) * PW'(s1_r_q);

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      s2_frac_q <= slope_prod[PW-1:RFW];
      s2_lo_q   <= s1_lo_q;
      s2_x_q    <= s1_x_q;
      s2_y_q    <= s1_y_q;
    end
  end

  // ---------------------------------------------------------------- stage 3
  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      s3_sig_q <= s2_lo_q + s2_frac_q;
      s3_x_q   <= s2_x_q;
      s3_y_q   <= s2_y_q;
    end
  end

  // ---------------------------------------------------------------- stage 4
  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      s4_xs_q <= XSW'(s3_x_q) * XSW'(signed'({1'b0, s3_sig_q}));
      s4_y_q  <= s3_y_q;
    end
  end

  // ---------------------------------------------------------------- stage 5
  always_ff @(posedge clk_i) begin
    if (ld[5]) begin
      s5_full_q <= FW'(s4_xs_q) * FW'(s4_y_q);
    end
  end

  // ---------------------------------------------------------------- stage 6
  always_comb begin
    // round half toward plus infinity, then floor shift
    rnd_sum = s5_full_q + HALF;
    rnd_res = RW'(rnd_sum >>> (2 * F));
    if (rnd_res > RES_MAX) begin
      sat_res  = PRODUCT_MAX;
      sat_flag = 1'b1;
    end else if (rnd_res < RES_MIN) begin
      sat_res  = PRODUCT_MIN;
      sat_flag = 1'b1;
    end else begin
      sat_res  = rnd_res[OPERAND_W-1:0];
      sat_flag = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[6]) begin
      s6_product_q <= sat_res;
      s6_sat_q     <= sat_flag;
    end
  end

  assign out_o.valid         = v_q[NS-1];
  assign out_o.product       = s6_product_q;
  assign out_o.saturated     = s6_sat_q;
  assign out_o.row_end_out   = row_q[NS-1];
  assign out_o.batch_end_out = batch_q[NS-1];

  // ---------------------------------------------------------------- checks
  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.saturated |->
      (out_o.product == PRODUCT_MAX || out_o.product == PRODUCT_MIN))
    else $error("saturated result not at a limit");

  a_sig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[3] |-> s3_sig_q <= SIG_ONE)
    else $error("interpolated sigmoid above one");

  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[NS-1] |-> in_i.ready)
    else $error("input stalled with empty output stage");

  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |->
      int'($countones(v_q)) == int'($countones($past(v_q)))
        + int'($past(in_i.valid && in_i.ready))
        - int'($past(out_o.valid && out_o.ready)))
    else $error("pipeline lost or duplicated an item");

endmodule

>>> tb/sv/silu_gated_multiply_top_tb.sv
// Testbench for silu_gated_multiply_top: drives operand pairs through sgm_in_if,
// predicts x * sigmoid(x) * y with its own knot table, checks every sgm_out_if transfer.
// Depends on sgm_pkg, sgm_in_if, sgm_out_if and the block itself.
module silu_gated_multiply_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sgm_pkg::*;

  typedef longint unsigned u64_t;

  localparam int unsigned FRAC_BITS        = DEF_FRAC_BITS;
  localparam int unsigned SIGMOID_SEGMENTS = DEF_SIGMOID_SEGMENTS;
  localparam u64_t        Q30              = u64_t'(1) << 30;
  localparam int          HOLD_CYCLES      = 40;
  localparam int          STALL_LIMIT      = 4000;
  localparam int          TAIL_CYCLES      = 12;

  typedef enum int unsigned {
    STYLE_ANY,
    STYLE_NEAR_ZERO,
    STYLE_LARGE,
    STYLE_KNOT
  } operand_style_e;

  typedef struct {
    logic signed [OPERAND_W-1:0] x;
    logic signed [OPERAND_W-1:0] y;
    logic signed [OPERAND_W-1:0] product;
    logic                        saturated;
    logic                        row_end;
    logic                        batch_end;
  } pair_expect_t;

  typedef struct packed {
    logic signed [OPERAND_W-1:0] x;
    logic signed [OPERAND_W-1:0] y;
    logic                        row_end;
    logic                        batch_end;
    logic                        typed;
    logic signed [OPERAND_W-1:0] product;
    logic                        saturated;
  } directed_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  sgm_in_if  in_if ();
  sgm_out_if out_if ();

  silu_gated_multiply_top #(
    .FRAC_BITS       (FRAC_BITS),
    .SIGMOID_SEGMENTS(SIGMOID_SEGMENTS)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #5 clk_i = ~clk_i;

  u64_t         sigmoid_knots [SIGMOID_SEGMENTS+1];
  pair_expect_t pending_products [$];
  int           mismatches      = 0;
  int           send_idle_pct   = 0;
  int           recv_stall_pct  = 0;
  int           hold_requests   = 0;
  logic         hold_active     = 1'b0;
  int           stalled_cycles  = 0;
  int           row_left        = 0;
  int           rows_left       = 0;

  // Extremes, zero operands, segment boundaries and saturation of both signs.
  directed_row_t directed_rows [23] = '{
    '{16'sd0,       16'sd0,      1'b0, 1'b0, 1'b1, 16'sd0,      1'b0},
    '{16'sd0,       PRODUCT_MAX, 1'b0, 1'b0, 1'b1, 16'sd0,      1'b0},
    '{16'sd0,       PRODUCT_MIN, 1'b1, 1'b0, 1'b1, 16'sd0,      1'b0},
    '{PRODUCT_MAX,  16'sd0,      1'b0, 1'b0, 1'b1, 16'sd0,      1'b0},
    '{PRODUCT_MIN,  16'sd0,      1'b1, 1'b1, 1'b1, 16'sd0,      1'b0},
    '{PRODUCT_MAX,  PRODUCT_MAX, 1'b0, 1'b0, 1'b1, PRODUCT_MAX, 1'b1},
    '{PRODUCT_MAX,  PRODUCT_MIN, 1'b1, 1'b0, 1'b1, PRODUCT_MIN, 1'b1},
    '{PRODUCT_MIN,  PRODUCT_MAX, 1'b0, 1'b0, 1'b0, 16'sd0,      1'b0},
    '{PRODUCT_MIN,  PRODUCT_MIN, 1'b0, 1'b1, 1'b0, 16'sd0,      1'b0},
    '{16'sd4096,    16'sd4096,   1'b0, 1'b0, 1'b0, 16'sd0,      1'b0},
    '{-16'sd4096,   16'sd4096,   1'b0, 1'b0, 1'b0, 16'sd0,      1'b0},
    '{16'sd1024,    -16'sd4096,  1'b1, 1'b0, 1'b0, 16'sd0,      1'b0},
    '{-16'sd1024,   16'sd12345,  1'b0, 1'b0, 1'b0, 16'sd0,      1'b0},
    '{16'sd1,       16'sd1,      1'b0, 1'b0, 1'b0, 16'sd0,      1'b0},
    '{-16'sd1,      -16'sd1,     1'b0, 1'b0, 1'b0, 16'sd0,      1'b0},
    '{16'sd20000,   16'sd20000,  1'b0, 1'b0, 1'b0, 16'sd0,      1'b0},
    '{16'sd30000,   -16'sd30000, 1'b0, 1'b0, 1'b0, 16'sd0,      1'b0},
    '{-16'sd20000,  16'sd30000,  1'b1, 1'b0, 1'b0, 16'sd0,      1'b0},
    '{16'sh5555,    16'shAAAA,   1'b0, 1'b0, 1'b0, 16'sd0,      1'b0},
    '{16'shAAAA,    16'sh5555,   1'b1, 1'b1, 1'b0, 16'sd0,      1'b0},
    '{-16'sd32767,  PRODUCT_MAX, 1'b0, 1'b0, 1'b0, 16'sd0,      1'b0},
    '{16'sd31744,   16'sd1,      1'b0, 1'b0, 1'b0, 16'sd0,      1'b0},
    '{16'sd2048,    16'sd8192,   1'b1, 1'b1, 1'b0, 16'sd0,      1'b0}
  };

  // Sigmoid knots at -8 + 16k/S: e^(-1/S) from a series through the 12th-order term in Q30, raised by
  // repeated truncating multiply, then v / (1 + v) rounded half up.
  initial begin : knot_table_build
    u64_t e_step;
    u64_t term;
    u64_t v;
    u64_t den;
    u64_t q;
    int   n;
    int   mag;
    e_step = Q30;
    term   = Q30;
    for (int j = 1; j <= 12; j++) begin
      term = term / (u64_t'(SIGMOID_SEGMENTS) * u64_t'(j));
      if (j % 2 == 1) begin
        e_step = e_step - term;
      end else begin
        e_step = e_step + term;
      end
    end
    for (int k = 0; k <= SIGMOID_SEGMENTS; k++) begin
      n   = 16 * k - 8 * int'(SIGMOID_SEGMENTS);
      mag = (n < 0) ? -n : n;
      v   = Q30;
      repeat (mag) v = (v * e_step) >> 30;
      den = Q30 + v;
      q   = ((v << FRAC_BITS) + den / 2) / den;
      sigmoid_knots[k] = (n < 0) ? q : (u64_t'(1) << FRAC_BITS) - q;
    end
  end

  function automatic pair_expect_t predict_pair(input logic signed [OPERAND_W-1:0] x,
                                                input logic signed [OPERAND_W-1:0] y,
                                                input logic row_end, input logic batch_end);
    longint       lim;
    longint       xc;
    longint       sig;
    longint       full;
    longint       rounded;
    u64_t         t;
    u64_t         seg;
    u64_t         r;
    u64_t         lo;
    u64_t         hi;
    pair_expect_t res;
    lim = longint'(8) << FRAC_BITS;
    xc  = longint'(x);
    if (xc < -lim) begin
      xc = -lim;
    end else if (xc > lim) begin
      xc = lim;
    end
    t   = u64_t'(xc + lim) * u64_t'(SIGMOID_SEGMENTS);
    seg = t >> (FRAC_BITS + 4);
    r   = t & ((u64_t'(1) << (FRAC_BITS + 4)) - 1);
    if (seg >= u64_t'(SIGMOID_SEGMENTS)) begin
      sig = longint'(sigmoid_knots[SIGMOID_SEGMENTS]);
    end else begin
      lo  = sigmoid_knots[seg];
      hi  = sigmoid_knots[seg + 1];
      sig = longint'(lo + (((hi - lo) * r) >> (FRAC_BITS + 4)));
    end
    // unclamped x in the multiply, round half up, then clip
    full    = longint'(x) * sig * longint'(y);
    rounded = (full + (longint'(1) << (2 * FRAC_BITS - 1))) >>> (2 * FRAC_BITS);
    res.x         = x;
    res.y         = y;
    res.row_end   = row_end;
    res.batch_end = batch_end;
    res.saturated = 1'b1;
    if (rounded > 32767) begin
      res.product = PRODUCT_MAX;
    end else if (rounded < -32768) begin
      res.product = PRODUCT_MIN;
    end else begin
      res.product   = OPERAND_W'(rounded);
      res.saturated = 1'b0;
    end
    return res;
  endfunction

  function automatic logic signed [OPERAND_W-1:0] pick_operand(input operand_style_e style);
    int v;
    case (style)
      STYLE_NEAR_ZERO: begin
        v = int'($urandom_range(4096)) - 2048;
      end
      STYLE_LARGE: begin
        v = int'($urandom_range(32767, 16384));
        if ($urandom_range(1) == 1) v = -v - int'($urandom_range(1));
      end
      STYLE_KNOT: begin
        v = int'($urandom_range(63)) * 1024 - 32768 + int'($urandom_range(2)) - 1;
      end
      default: begin
        v = int'($urandom);
      end
    endcase
    return OPERAND_W'(v);
  endfunction

  task automatic note_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic offer_pair(input logic signed [OPERAND_W-1:0] x,
                            input logic signed [OPERAND_W-1:0] y,
                            input logic row_end, input logic batch_end,
                            input pair_expect_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.silu_operand  <= x;
    in_if.scale_operand <= y;
    in_if.row_end       <= row_end;
    in_if.batch_end     <= batch_end;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    pending_products.push_back(want);
  endtask

  task automatic drain_pipeline();
    in_if.valid <= 1'b0;
    while (pending_products.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  // Mostly well-formed rows and batches; one pair in ten gets random marks.
  task automatic run_random_pairs(input int count);
    logic signed [OPERAND_W-1:0] x;
    logic signed [OPERAND_W-1:0] y;
    logic                        row_end;
    logic                        batch_end;
    for (int i = 0; i < count; i++) begin
      if (row_left == 0) begin
        row_left = $urandom_range(16, 1);
        if (rows_left == 0) rows_left = $urandom_range(4, 1);
      end
      row_end   = (row_left == 1);
      batch_end = row_end && (rows_left == 1);
      row_left--;
      if (row_end) rows_left--;
      if ($urandom_range(9) == 0) begin
        row_end   = 1'($urandom_range(1));
        batch_end = 1'($urandom_range(1));
      end
      x = pick_operand(operand_style_e'($urandom_range(3)));
      y = pick_operand(operand_style_e'($urandom_range(3)));
      offer_pair(x, y, row_end, batch_end, predict_pair(x, y, row_end, batch_end));
    end
    drain_pipeline();
  endtask

  // Receiver: check each output transfer against the oldest pending product.
  always @(posedge clk_i) begin : result_check
    pair_expect_t want;
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_products.size() == 0) begin
        note_mismatch($sformatf("product %0d with nothing pending", out_if.product));
      end else begin
        want = pending_products.pop_front();
        if (out_if.product !== want.product)
          note_mismatch($sformatf("product %0d, expected %0d (x=%0d y=%0d)",
                                  out_if.product, want.product, want.x, want.y));
        if (out_if.saturated !== want.saturated)
          note_mismatch($sformatf("saturated %b, expected %b (x=%0d y=%0d)",
                                  out_if.saturated, want.saturated, want.x, want.y));
        if (out_if.row_end_out !== want.row_end)
          note_mismatch($sformatf("row_end_out %b, expected %b (x=%0d y=%0d)",
                                  out_if.row_end_out, want.row_end, want.x, want.y));
        if (out_if.batch_end_out !== want.batch_end)
          note_mismatch($sformatf("batch_end_out %b, expected %b (x=%0d y=%0d)",
                                  out_if.batch_end_out, want.batch_end, want.x, want.y));
      end
    end
    out_if.ready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
  end

  // Long receiver hold-off, so the pipeline fills and backs up into the input.
  initial begin : receiver_hold
    int served;
    served = 0;
    forever begin
      @(posedge clk_i);
      if (hold_requests != served) begin
        served = hold_requests;
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_active <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= STALL_LIMIT) begin
      $display("silu_gated_multiply_top_tb: FAIL");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  initial begin : stimulus
    directed_row_t row;
    pair_expect_t  want;
    rst_ni              <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.silu_operand  <= '0;
    in_if.scale_operand <= '0;
    in_if.row_end       <= 1'b0;
    in_if.batch_end     <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idling(0, 0);
    for (int i = 0; i < $size(directed_rows); i++) begin
      row  = directed_rows[i];
      want = predict_pair(row.x, row.y, row.row_end, row.batch_end);
      if (row.typed) begin
        want.product   = row.product;
        want.saturated = row.saturated;
      end
      offer_pair(row.x, row.y, row.row_end, row.batch_end, want);
    end
    drain_pipeline();

    run_random_pairs(300);
    set_idling(86, 0);
    run_random_pairs(250);
    set_idling(0, 86);
    run_random_pairs(250);
    set_idling(27, 27);
    run_random_pairs(300);
    set_idling(0, 0);
    hold_requests <= hold_requests + 1;
    run_random_pairs(80);
    set_idling(27, 27);
    run_random_pairs(300);
    set_idling(0, 0);
    run_random_pairs(150);

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_products.size() == 0) begin
      $display("silu_gated_multiply_top_tb: PASS");
    end else begin
      $display("silu_gated_multiply_top_tb: FAIL");
    end
    $finish;
  end

endmodule
